[sv/cfc_pkg.sv]
// ----------------------------------------------------------------------------
// cfc_pkg
// Shared types, constants and a helper function of the control frame composer.
// ----------------------------------------------------------------------------
package cfc_pkg;

	// Largest payload a frame may carry; the configured count saturates here.
	localparam int unsigned MAX_PAYLOAD = 1024;
	localparam int unsigned LEN_W       = 11;
	localparam int unsigned CFG_DATA_W  = 32;
	localparam int unsigned CFG_IDX_W   = 3;
	localparam int unsigned STEP_W      = 4;

	localparam logic [7:0] MARK_D     = 8'h44;
	localparam logic [7:0] MARK_S     = 8'h53;
	localparam logic [15:0] FRAME_OVH = 16'd12;
	localparam logic [7:0] MSG_MASK   = 8'he0;
	localparam logic [7:0] DATA_MASK  = 8'h1c;
	localparam logic [7:0] MACH_MASK  = 8'h03;

	// Position of the last header byte and of a checksum that follows it directly.
	localparam logic [STEP_W-1:0] HDR_LAST  = 4'd10;
	localparam logic [STEP_W-1:0] CSUM_STEP = 4'd11;

	// Request codes on the input channel.
	localparam logic REQ_START = 1'b0;
	localparam logic REQ_DATA  = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MSG_CODE     = 3'd0,
		CFG_DATA_CODE    = 3'd1,
		CFG_MACHINE_CODE = 3'd2,
		CFG_PAYLOAD_LEN  = 3'd3,
		CFG_DEST_ADDR    = 3'd4
	} cfg_idx_t;

	// Header fields prepared from the configuration registers.
	typedef struct packed {
		logic [7:0]       info;
		logic [15:0]      total;
		logic [31:0]      dest;
		logic [LEN_W-1:0] cnt;
	} hdr_t;

	// One result byte headed for the output register.
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} res_t;

	function automatic logic [7:0] hdr_byte(logic [STEP_W-1:0] step, hdr_t h);
		logic [7:0] b;
		unique case (step)
			4'd0, 4'd2: b = MARK_D;
			4'd1, 4'd3: b = MARK_S;
			4'd4:       b = h.info;
			4'd5:       b = h.total[15:8];
			4'd6:       b = h.total[7:0];
			4'd7:       b = h.dest[7:0];
			4'd8:       b = h.dest[15:8];
			4'd9:       b = h.dest[23:16];
			4'd10:      b = h.dest[31:24];
			default:    b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

[sv/cfc_in_if.sv]
// ----------------------------------------------------------------------------
// cfc_in_if
// Request channel: start requests and payload bytes with valid/ready.
// ----------------------------------------------------------------------------
interface cfc_in_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] payload_byte;

	modport source (output valid, output req_type, output payload_byte, input ready);
	modport sink (input valid, input req_type, input payload_byte, output ready);
endinterface

[sv/cfc_out_if.sv]
// ----------------------------------------------------------------------------
// cfc_out_if
// Frame byte channel: one composed byte per transaction with valid/ready.
// ----------------------------------------------------------------------------
interface cfc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       frame_end;

	modport source (output valid, output out_byte, output frame_end, input ready);
	modport sink (input valid, input out_byte, input frame_end, output ready);
endinterface

[sv/cfc_cfg.sv]
// ----------------------------------------------------------------------------
// cfc_cfg
// Configuration registers and the header fields derived from them.
// ----------------------------------------------------------------------------
module cfc_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [cfc_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [cfc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output cfc_pkg::hdr_t                    hdr
);

	logic [3:0]                  msg_code_q;
	logic [2:0]                  data_code_q;
	logic [1:0]                  machine_code_q;
	logic [cfc_pkg::LEN_W-1:0]   payload_len_q;
	logic [31:0]                 dest_addr_q;
	logic [cfc_pkg::LEN_W-1:0]   cnt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg_code_q     <= '0;
			data_code_q    <= '0;
			machine_code_q <= '0;
			payload_len_q  <= '0;
			dest_addr_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfc_pkg::cfg_idx_t'(cfg_idx))
				cfc_pkg::CFG_MSG_CODE:     msg_code_q     <= cfg_wdata[3:0];
				cfc_pkg::CFG_DATA_CODE:    data_code_q    <= cfg_wdata[2:0];
				cfc_pkg::CFG_MACHINE_CODE: machine_code_q <= cfg_wdata[1:0];
				cfc_pkg::CFG_PAYLOAD_LEN:  payload_len_q  <= cfg_wdata[cfc_pkg::LEN_W-1:0];
				cfc_pkg::CFG_DEST_ADDR:    dest_addr_q    <= cfg_wdata[31:0];
				default: ;
			endcase
		end
	end

	// Counts above the maximum saturate, both in the count and the length field.
	assign cnt = (payload_len_q > cfc_pkg::LEN_W'(cfc_pkg::MAX_PAYLOAD))
		? cfc_pkg::LEN_W'(cfc_pkg::MAX_PAYLOAD) : payload_len_q;

	always_comb begin
		hdr.info  = ({msg_code_q, 4'b0000} & cfc_pkg::MSG_MASK)
			| ({3'b000, data_code_q, 2'b00} & cfc_pkg::DATA_MASK)
			| ({6'b000000, machine_code_q} & cfc_pkg::MACH_MASK);
		hdr.total = 16'(cnt) + cfc_pkg::FRAME_OVH;
		hdr.dest  = dest_addr_q;
		hdr.cnt   = cnt;
	end

endmodule

[sv/cfc_seq.sv]
// ----------------------------------------------------------------------------
// cfc_seq
// Input register and byte sequencer: turns each request into frame bytes,
// dropping payload bytes that arrive with no frame open.
module cfc_seq (
	input  logic           clk,
	input  logic           arst_n,
	cfc_in_if.sink         in_chan,
	input  cfc_pkg::hdr_t  hdr,
	input  logic           out_space,
	output logic           push,
	output cfc_pkg::res_t  res
);

	logic                         valid_s1;
	logic                         req_s1;
	logic [7:0]                   pb_s1;
	logic [cfc_pkg::STEP_W-1:0]   step_q;
	logic [cfc_pkg::STEP_W-1:0]   nstep;
	logic                         frame_open_q;
	logic [cfc_pkg::LEN_W-1:0]    left_q;
	logic [cfc_pkg::LEN_W-1:0]    left_dec;
	logic [7:0]                   sum_q;
	logic                         is_start;
	logic                         emit;
	logic                         done;
	logic                         adv;
	logic                         fin;

	assign is_start = (req_s1 == cfc_pkg::REQ_START);
	assign left_dec = (left_q != '0) ? left_q - cfc_pkg::LEN_W'(1) : left_q;

	always_comb begin
		emit     = 1'b0;
		res.data = 8'h00;
		res.last = 1'b0;
		done     = 1'b1;
		nstep    = '0;
		if (valid_s1) begin
			if (is_start) begin
				if (step_q <= cfc_pkg::HDR_LAST) begin
					emit     = 1'b1;
					res.data = cfc_pkg::hdr_byte(step_q, hdr);
					nstep    = step_q + cfc_pkg::STEP_W'(1);
					done     = (step_q == cfc_pkg::HDR_LAST) && (hdr.cnt != '0);
				end else begin
					emit     = 1'b1;
					res.data = sum_q;
					res.last = 1'b1;
				end
			end else if (step_q == '0) begin
				if (frame_open_q) begin
					emit     = 1'b1;
					res.data = pb_s1;
					nstep    = cfc_pkg::STEP_W'(1);
					done     = (left_dec != '0);
				end
			end else begin
				emit     = 1'b1;
				res.data = sum_q;
				res.last = 1'b1;
			end
		end
	end

	assign adv  = valid_s1 && (!emit || out_space);
	assign fin  = adv && done;
	assign push = adv && emit;
	assign in_chan.ready = !valid_s1 || fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_chan.valid && in_chan.ready) begin
			valid_s1 <= 1'b1;
		end else if (fin) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_chan.valid && in_chan.ready) begin
			req_s1 <= in_chan.req_type;
			pb_s1  <= in_chan.payload_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q       <= '0;
			frame_open_q <= 1'b0;
			left_q       <= '0;
			sum_q        <= '0;
		end else if (adv) begin
			step_q <= done ? '0 : nstep;
			if (emit && !res.last) begin
				sum_q <= (is_start && step_q == '0) ? res.data : sum_q + res.data;
			end
			if (is_start && step_q == cfc_pkg::HDR_LAST) begin
				frame_open_q <= 1'b1;
				left_q       <= hdr.cnt;
			end
			if (!is_start && step_q == '0 && frame_open_q) begin
				left_q <= left_dec;
			end
			if (emit && res.last) begin
				frame_open_q <= 1'b0;
				left_q       <= '0;
			end
		end
	end

	// A checksum byte always closes the frame.
	a_csum_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(push && res.last) |=> !frame_open_q)
		else $error("frame still open after checksum");

	// The step counter only runs while a request is held.
	a_step_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> (step_q == '0))
		else $error("step counter moved without a request");

	// No step past the checksum that follows an empty frame's header.
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= cfc_pkg::CSUM_STEP)
		else $error("step counter out of range");

	// Between requests, an open frame always expects at least one more payload
	// byte; only a pending checksum step may see an open frame with none left.
	a_open_left: assert property (@(posedge clk) disable iff (!arst_n)
		(frame_open_q && step_q == '0) |-> (left_q != '0))
		else $error("open frame with nothing left");

endmodule

[sv/cfc_out_reg.sv]
// ----------------------------------------------------------------------------
// cfc_out_reg
// Output register that holds one frame byte until the sink takes it.
// ----------------------------------------------------------------------------
module cfc_out_reg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  cfc_pkg::res_t  res,
	output logic           out_space,
	cfc_out_if.source      out_chan
);

	logic          valid_q;
	cfc_pkg::res_t data_q;

	assign out_space = !valid_q || out_chan.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (out_chan.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			data_q <= res;
		end
	end

	assign out_chan.valid     = valid_q;
	assign out_chan.out_byte  = data_q.data;
	assign out_chan.frame_end = data_q.last;

endmodule

[sv/control_frame_composer_unit.sv]
// ----------------------------------------------------------------------------
// control_frame_composer_unit
// Composes outgoing control frames as a byte stream.
// ----------------------------------------------------------------------------
// A start request (req_type 0) produces the eleven header bytes "DSDS", the
// info byte, the big-endian length (payload count plus 12) and the four
// destination address octets, low octet first. Payload bytes (req_type 1)
// pass through one per transaction, and after the configured count a
// mod-256 checksum of every earlier frame byte follows with frame_end set.
// A start with a count of zero emits the checksum right after the header.
// Payload bytes that arrive with no frame open are dropped without output.
// Rate: payload streams at one transaction per cycle while the sink keeps
// up; the last payload byte holds the input until the checksum that follows
// it is out too. A start request holds the input while the header bytes, and
// for an empty frame the checksum, are emitted; the sequencer produces one
// byte per cycle while the sink keeps up. The first byte of a request passes
// through the input register, then the output register, before it reaches
// the output. Configuration writes take effect at the next start request
// and should only be issued while the unit is idle.
// ----------------------------------------------------------------------------
module control_frame_composer_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [cfc_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [cfc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	cfc_in_if.sink                          in_chan,
	cfc_out_if.source                       out_chan
);

	cfc_pkg::hdr_t hdr;
	cfc_pkg::res_t res;
	logic          push;
	logic          out_space;

	// Configuration registers and the prepared header fields.
	cfc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.hdr       (hdr)
	);

	// The sequencer walks one held request through its bytes and keeps the
	// frame state: whether a frame is open, the bytes left and the running sum.
	cfc_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_chan   (in_chan),
		.hdr       (hdr),
		.out_space (out_space),
		.push      (push),
		.res       (res)
	);

	// The output register decouples the sink; it reloads in the same cycle
	// that its current byte is taken.
	cfc_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.res       (res),
		.out_space (out_space),
		.out_chan  (out_chan)
	);

endmodule
